// File: rtl/tdes_pkg.sv
// ----------------------------------------------------------------------------
// tdes_pkg: shared types, tables and functions for the Triple DES pipeline.
// Holds the DES permutations, the S-boxes, the round function and the
// key schedule helpers used by the round cells and the top level.
// ----------------------------------------------------------------------------
package tdes_pkg;

  localparam int NumRounds = 48;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegKeyOne   = 2'd0;
  localparam logic [1:0] RegKeyTwo   = 2'd1;
  localparam logic [1:0] RegKeyThree = 2'd2;

  // Data carried from one round cell to the next.
  typedef struct packed {
    logic        vld;
    logic [31:0] l;
    logic [31:0] r;
    logic        dec;
  } stage_t;

  // Flow control shared by the cells.
  typedef struct packed {
    logic adv;
  } ctrl_t;

  typedef logic [7:0] ptab_t [64];

  localparam ptab_t IpTab = '{
    8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2, 8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
    8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6, 8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
    8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,  8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
    8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5, 8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};

  localparam ptab_t FpTab = '{
    8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32, 8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
    8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30, 8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
    8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28, 8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
    8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26, 8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};

  localparam logic [7:0] ETab [48] = '{
    8'd32,8'd1,8'd2,8'd3,8'd4,8'd5, 8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
    8'd8,8'd9,8'd10,8'd11,8'd12,8'd13, 8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
    8'd16,8'd17,8'd18,8'd19,8'd20,8'd21, 8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
    8'd24,8'd25,8'd26,8'd27,8'd28,8'd29, 8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};

  localparam logic [7:0] PTab [32] = '{
    8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17, 8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
    8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,    8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};

  localparam logic [7:0] Pc1Tab [56] = '{
    8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9, 8'd1,8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,
    8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27, 8'd19,8'd11,8'd3,8'd60,8'd52,8'd44,8'd36,
    8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15, 8'd7,8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,
    8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,8'd29, 8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};

  localparam logic [7:0] Pc2Tab [48] = '{
    8'd14,8'd17,8'd11,8'd24,8'd1,8'd5, 8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,
    8'd23,8'd19,8'd12,8'd4,8'd26,8'd8, 8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,
    8'd41,8'd52,8'd31,8'd37,8'd47,8'd55, 8'd30,8'd40,8'd51,8'd45,8'd33,8'd48,
    8'd44,8'd49,8'd39,8'd56,8'd34,8'd53, 8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};

  // Total left rotation of C and D after each round, counted from PC1.
  localparam logic [4:0] RotSum [16] = '{
    5'd1,5'd2,5'd4,5'd6,5'd8,5'd10,5'd12,5'd14,
    5'd15,5'd17,5'd19,5'd21,5'd23,5'd25,5'd27,5'd28};

  localparam logic [3:0] SBox [8][64] = '{
   '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
     4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
     4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
     4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
   '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
     4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
     4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
     4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
   '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
     4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
     4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
     4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
   '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
     4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
     4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
     4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
   '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
     4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
     4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
     4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
   '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
     4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
     4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
     4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
   '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
     4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
     4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
     4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
   '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
     4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
     4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
     4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  // Initial and final permutations of a 64-bit block (bit 1 is the MSB).
  function automatic logic [63:0] perm64(input logic [63:0] v, input ptab_t t);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-t[i]];
    return r;
  endfunction

  // Round subkey: PC1, rotate both halves by the round's total, then PC2.
  function automatic logic [47:0] subkey(input logic [63:0] key, input logic [3:0] rnd);
    logic [55:0] cd;
    logic [27:0] c, d;
    logic [55:0] cdr;
    logic [47:0] k;
    logic [4:0]  s;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64-Pc1Tab[i]];
    s = RotSum[rnd];
    c = cd[55:28];
    d = cd[27:0];
    c = (c << s) | (c >> (5'd28 - s));
    d = (d << s) | (d >> (5'd28 - s));
    cdr = {c, d};
    for (int i = 0; i < 48; i++) k[47-i] = cdr[56-Pc2Tab[i]];
    return k;
  endfunction

  // Feistel function: E, key mix, S-boxes and P.
  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] so;
    logic [31:0] f;
    logic [5:0]  b;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-ETab[i]];
    x = x ^ k;
    for (int j = 0; j < 8; j++) begin
      b = x[47-6*j -: 6];
      so[31-4*j -: 4] = SBox[j][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) f[31-i] = so[32-PTab[i]];
    return f;
  endfunction

endpackage

// File: rtl/tdes_round_cell.sv
// ----------------------------------------------------------------------------
// tdes_round_cell: one Feistel round of the Triple DES chain.
// Applies the round function with its subkey and registers the halves,
// handing them to the next cell when the chain advances.
// ----------------------------------------------------------------------------
module tdes_round_cell
  import tdes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  input  stage_t      din,
  input  logic [47:0] sk,
  output stage_t      dout
);

  logic [31:0] f;

  // Round function on the incoming right half.
  assign f = feistel(din.r, sk);

  // Stage register; only the valid bit needs reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (ctrl.adv) begin
      dout.vld <= din.vld;
    end
    if (ctrl.adv) begin
      dout.l   <= din.r;
      dout.r   <= din.l ^ f;
      dout.dec <= din.dec;
    end
  end

endmodule

// File: rtl/triple_des_ede_block_cipher.sv
// ----------------------------------------------------------------------------
// triple_des_ede_block_cipher: Triple DES (EDE3) pipeline.
// Forty-eight round cells in a row, one block accepted per cycle unless the chain is stalled.
//
//   Channel  Signals                                   Direction
//   in       in_valid, in_stall, block_in, req_type   request in
//   out      out_valid, out_stall, block_out          request out
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data key writes
//
// One request per cycle is accepted while the chain advances; each is registered once per round cell.
// Each DES pass ends with FP and the next starts with IP, which cancel, so
// the chain only swaps halves between passes.
// A stall on the output while a result is held freezes the whole chain; in_stall follows it.
// Reset clears the valid bits and the three keys.
// ----------------------------------------------------------------------------
module triple_des_ede_block_cipher
  import tdes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] block_in,
  input  logic        req_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] block_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_one, key_two, key_three;
  stage_t      st [NumRounds+1];
  ctrl_t       ctrl;
  logic [63:0] ipv;
  logic [63:0] pre_fp;

  // Chain advances unless a held result is blocked.
  assign ctrl.adv  = !(st[NumRounds].vld && out_stall);
  assign in_stall  = !ctrl.adv;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_one   <= '0;
      key_two   <= '0;
      key_three <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegKeyOne:   key_one   <= cfg_data;
        RegKeyTwo:   key_two   <= cfg_data;
        RegKeyThree: key_three <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry of the chain after IP.
  assign ipv = perm64(block_in, IpTab);
  always_comb begin
    st[0].vld = in_valid;
    st[0].l   = ipv[63:32];
    st[0].r   = ipv[31:0];
    st[0].dec = req_type;
  end

  // Round cells with their subkeys chosen by direction.
  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    localparam int Pass = g / 16;
    localparam int Rnd  = g % 16;
    logic [63:0] kenc, kdec;
    logic [47:0] sk;
    logic        pass_dec;
    stage_t      cin;
    assign kenc = (Pass == 0) ? key_one : (Pass == 1) ? key_two : key_three;
    assign kdec = (Pass == 0) ? key_three : (Pass == 1) ? key_two : key_one;
    // Middle pass runs opposite to the request direction.
    assign pass_dec = (Pass == 1) ? !st[g].dec : st[g].dec;
    assign sk = pass_dec ? subkey(st[g].dec ? kdec : kenc, 4'(15 - Rnd))
                         : subkey(st[g].dec ? kdec : kenc, 4'(Rnd));
    // Between passes the halves are swapped (FP then IP cancel).
    always_comb begin
      cin = st[g];
      if (Rnd == 0 && g != 0) begin
        cin.l = st[g].r;
        cin.r = st[g].l;
      end
    end
    tdes_round_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .din  (cin),
      .sk   (sk),
      .dout (st[g+1])
    );
  end

  assign pre_fp    = {st[NumRounds].r, st[NumRounds].l};
  assign block_out = perm64(pre_fp, FpTab);
  assign out_valid = st[NumRounds].vld;

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(block_out))
    else $error("held result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !in_valid |=> !st[1].vld)
    else $error("bubble not carried into chain");
`endif

endmodule
